// ===== rtl/ogi_pkg.sv =====
// Shared constants for the obstacle grid inflation unit: operation codes,
// register indexes, default register values and field widths.
// No dependencies.
`timescale 1ns / 1ps

package ogi_pkg;

	localparam int GRID_WIDTH_DEF  = 128;
	localparam int GRID_HEIGHT_DEF = 128;
	localparam int FRAC_BITS_DEF   = 8;

	localparam int POS_W  = 21;
	localparam int COST_W = 7;
	localparam int RAD_W  = 6;
	localparam int COL_W  = 8;
	localparam int IDX_W  = 3;

	localparam logic [1:0] OP_MARK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_CHECK = 2'd3;

	localparam logic [IDX_W-1:0] REG_ROBOT_RAD = 3'd0;
	localparam logic [IDX_W-1:0] REG_SQ_RAD    = 3'd1;
	localparam logic [IDX_W-1:0] REG_RECT_RAD  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SQ_COST   = 3'd3;
	localparam logic [IDX_W-1:0] REG_RECT_COST = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROBOT_COST = 3'd5;
	localparam logic [IDX_W-1:0] REG_STOP_COLS = 3'd6;

	localparam logic [RAD_W-1:0]  ROBOT_RAD_RST  = 6'd8;
	localparam logic [RAD_W-1:0]  SQ_RAD_RST     = 6'd2;
	localparam logic [RAD_W-1:0]  RECT_RAD_RST   = 6'd4;
	localparam logic [COST_W-1:0] SQ_COST_RST    = 7'd90;
	localparam logic [COST_W-1:0] RECT_COST_RST  = 7'd70;
	localparam logic [COST_W-1:0] ROBOT_COST_RST = 7'd50;
	localparam logic [COL_W-1:0]  STOP_COLS_RST  = 8'd22;

	localparam logic [COST_W-1:0] LETHAL = 7'd100;

endpackage

// ===== rtl/obstacle_grid_inflation_unit.sv =====
// Obstacle grid inflation unit: cost grid memory, mark/read/clear/check
// sequencer and a shared bit-per-cycle square root unit for ring offsets.
// Depends on ogi_pkg.
`timescale 1ns / 1ps
//
// channel   direction  ports                               word
// s_*       in         s_tvalid s_tready s_tdata s_tuser   one operation
// m_*       out        m_tvalid m_tready m_tdata           one result
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// One word at a time; s_tready is high only while the sequencer is idle.
// Read looks up one cell; clear sweeps the whole grid; check scans the grid with one
// grid read a cycle and stops at the first lethal cell. Mark checks the point cell, then per
// ring step sets up, takes the square root, visits the eight octant cells and advances;
// an on-grid octant cell takes a read and a write on the one memory port, an off-grid
// one has no memory access. After reset the grid is swept to zero before the first word
// is taken; config writes are always taken.
// A result waiting on m_tready holds the sequencer in its final state.

module obstacle_grid_inflation_unit import ogi_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // pos_x [20:0], pos_y [41:21], zeros
	input  logic [1:0]        s_tuser,   // operation [1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // cell_value [6:0], point_used [7], stop [8], zeros
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [7:0]        cfg_data
);

	localparam int XW    = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
	localparam int YW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = 2 * RAD_W;
	localparam int SQW   = NW + 2 * FRAC_BITS;
	localparam int GW    = SQW / 2;
	localparam int SCW   = $clog2(GW + 1);
	localparam int SUM_W = ((POS_W > FRAC_BITS + RAD_W + 1) ? POS_W : FRAC_BITS + RAD_W + 1) + 2;
	localparam int CW    = ((XW > COL_W) ? XW : COL_W) + 1;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_MCHK = 4'd2;
	localparam logic [3:0] ST_RSET = 4'd3;
	localparam logic [3:0] ST_SQRT = 4'd4;
	localparam logic [3:0] ST_PRD  = 4'd5;
	localparam logic [3:0] ST_PWR  = 4'd6;
	localparam logic [3:0] ST_NEXT = 4'd7;
	localparam logic [3:0] ST_RDW  = 4'd8;
	localparam logic [3:0] ST_CHK  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	localparam logic [AW-1:0] W_A = AW'(GRID_WIDTH);

	function automatic logic signed [SUM_W-1:0] trunc_cell(
		input logic signed [SUM_W-1:0] a, input logic inx);
		logic [SUM_W-1:0] mag;
		mag = -a - SUM_W'(inx);
		if (!a[SUM_W-1]) trunc_cell = a >>> FRAC_BITS;
		else trunc_cell = -$signed(mag >> FRAC_BITS);
	endfunction

	function automatic logic on_grid(input logic signed [SUM_W-1:0] cx,
		input logic signed [SUM_W-1:0] cy);
		on_grid = !cx[SUM_W-1] && !cy[SUM_W-1] &&
			(cx < $signed(SUM_W'(GRID_WIDTH))) && (cy < $signed(SUM_W'(GRID_HEIGHT)));
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
		input logic [YW-1:0] y);
		cell_addr = AW'(y) * W_A + AW'(x);
	endfunction

	// Configuration registers.
	logic [RAD_W-1:0]  robot_rad_q, sq_rad_q, rect_rad_q;
	logic [COST_W-1:0] sq_cost_q, rect_cost_q, robot_cost_q;
	logic [COL_W-1:0]  stop_cols_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_rad_q  <= ROBOT_RAD_RST;
			sq_rad_q     <= SQ_RAD_RST;
			rect_rad_q   <= RECT_RAD_RST;
			sq_cost_q    <= SQ_COST_RST;
			rect_cost_q  <= RECT_COST_RST;
			robot_cost_q <= ROBOT_COST_RST;
			stop_cols_q  <= STOP_COLS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROBOT_RAD:  robot_rad_q  <= cfg_data[RAD_W-1:0];
				REG_SQ_RAD:     sq_rad_q     <= cfg_data[RAD_W-1:0];
				REG_RECT_RAD:   rect_rad_q   <= cfg_data[RAD_W-1:0];
				REG_SQ_COST:    sq_cost_q    <= cfg_data[COST_W-1:0];
				REG_RECT_COST:  rect_cost_q  <= cfg_data[COST_W-1:0];
				REG_ROBOT_COST: robot_cost_q <= cfg_data[COST_W-1:0];
				REG_STOP_COLS:  stop_cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Grid memory, one access per cycle, registered read.
	logic [COST_W-1:0] grid_mem [DEPTH];
	logic [COST_W-1:0] rd_q;
	logic [AW-1:0]     mem_addr;
	logic              mem_we, mem_re;
	logic [COST_W-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[mem_addr] <= mem_wd;
		if (mem_re) rd_q <= grid_mem[mem_addr];
	end

	// Sequencer state.
	logic [3:0]              state_q;
	logic [AW-1:0]           clr_q;
	logic                    clr_op_q;
	logic signed [SUM_W-1:0] px_q, py_q;
	logic [AW-1:0]           pt_addr_q;
	logic [RAD_W-1:0]        r_q, k_q;
	logic [COST_W-1:0]       cost_q;
	logic [2:0]              oct_q;
	logic [SQW-1:0]          rem_q, res_q, bit_q;
	logic [SCW-1:0]          sq_cnt_q;
	logic [XW-1:0]           chk_x_q, chk_x_s1;
	logic [YW-1:0]           chk_y_q;
	logic                    chk_end_q, chk_pend_s1;
	logic [COST_W-1:0]       val_q;
	logic                    used_q, stop_q;

	// Input point cell.
	logic signed [SUM_W-1:0] in_px, in_py, in_cx, in_cy;
	logic                    in_on;
	logic [AW-1:0]           in_addr;
	logic                    accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		in_px   = SUM_W'($signed(s_tdata[POS_W-1:0]));
		in_py   = SUM_W'($signed(s_tdata[2*POS_W-1:POS_W]));
		in_cx   = trunc_cell(in_px, 1'b0);
		in_cy   = trunc_cell(in_py, 1'b0);
		in_on   = on_grid(in_cx, in_cy);
		in_addr = cell_addr(in_cx[XW-1:0], in_cy[YW-1:0]);
	end

	// Ring geometry for the current step and octant.
	logic [NW-1:0]           rr, kk, n_val;
	logic [NW:0]             two_kk;
	logic                    ix;
	logic signed [SUM_W-1:0] gx, ngx, ky, ox, oy, cx, cy;
	logic                    oxi, oyi, p_on;
	logic [AW-1:0]           p_addr;
	logic [SQW-1:0]          sq_t;
	logic                    sq_ge;

	always_comb begin
		rr     = NW'(r_q) * NW'(r_q);
		kk     = NW'(k_q) * NW'(k_q);
		two_kk = {kk, 1'b0};
		n_val  = rr - kk;
		ix     = |rem_q;
		gx     = $signed(SUM_W'(res_q[GW-1:0]));
		ngx    = -gx - SUM_W'(ix);
		ky     = $signed(SUM_W'(k_q) << FRAC_BITS);
		case (oct_q)
			3'd0: begin ox = gx;  oxi = ix;   oy = ky;  oyi = 1'b0; end
			3'd1: begin ox = ky;  oxi = 1'b0; oy = gx;  oyi = ix;   end
			3'd2: begin ox = -ky; oxi = 1'b0; oy = gx;  oyi = ix;   end
			3'd3: begin ox = ngx; oxi = ix;   oy = ky;  oyi = 1'b0; end
			3'd4: begin ox = ngx; oxi = ix;   oy = -ky; oyi = 1'b0; end
			3'd5: begin ox = -ky; oxi = 1'b0; oy = ngx; oyi = ix;   end
			3'd6: begin ox = ky;  oxi = 1'b0; oy = ngx; oyi = ix;   end
			default: begin ox = gx; oxi = ix; oy = -ky; oyi = 1'b0; end
		endcase
		cx     = trunc_cell(px_q + ox, oxi);
		cy     = trunc_cell(py_q + oy, oyi);
		p_on   = on_grid(cx, cy);
		p_addr = cell_addr(cx[XW-1:0], cy[YW-1:0]);
		sq_t   = res_q + bit_q;
		sq_ge  = rem_q >= sq_t;
	end

	// Memory port control.
	always_comb begin
		mem_addr = clr_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_wd   = '0;
		unique case (state_q)
			ST_CLR: mem_we = 1'b1;
			ST_IDLE: begin
				mem_addr = in_addr;
				mem_re   = accept && in_on && (s_tuser == OP_MARK || s_tuser == OP_READ);
			end
			ST_MCHK: begin
				mem_addr = pt_addr_q;
				mem_we   = (rd_q != LETHAL);
				mem_wd   = LETHAL;
			end
			ST_PRD: begin
				mem_addr = p_addr;
				mem_re   = p_on;
			end
			ST_PWR: begin
				mem_addr = p_addr;
				mem_we   = cost_q > rd_q;
				mem_wd   = cost_q;
			end
			ST_CHK: begin
				mem_addr = cell_addr(chk_x_q, chk_y_q);
				mem_re   = !chk_end_q;
			end
			default: ;
		endcase
	end

	// Result register: loaded when the sequencer finishes and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
			m_tdata  <= {7'd0, stop_q, used_q, val_q};
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			clr_op_q    <= 1'b0;
			chk_pend_s1 <= 1'b0;
			chk_end_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= clr_op_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						val_q     <= '0;
						used_q    <= 1'b0;
						stop_q    <= 1'b0;
						px_q      <= in_px;
						py_q      <= in_py;
						pt_addr_q <= in_addr;
						case (s_tuser)
							OP_MARK:  state_q <= in_on ? ST_MCHK : ST_DONE;
							OP_READ:  state_q <= in_on ? ST_RDW : ST_DONE;
							OP_CLEAR: begin
								clr_op_q <= 1'b1;
								clr_q    <= '0;
								state_q  <= ST_CLR;
							end
							default: begin
								chk_x_q     <= '0;
								chk_y_q     <= '0;
								chk_end_q   <= 1'b0;
								chk_pend_s1 <= 1'b0;
								state_q     <= ST_CHK;
							end
						endcase
					end
				end
				ST_RDW: begin
					val_q   <= rd_q;
					state_q <= ST_DONE;
				end
				ST_MCHK: begin
					if (rd_q != LETHAL) begin
						used_q  <= 1'b1;
						r_q     <= RAD_W'(1);
						k_q     <= '0;
						state_q <= (robot_rad_q != '0) ? ST_RSET : ST_DONE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RSET: begin
					if (r_q <= sq_rad_q) cost_q <= sq_cost_q;
					else if (r_q <= rect_rad_q) cost_q <= rect_cost_q;
					else cost_q <= robot_cost_q;
					rem_q    <= SQW'(n_val) << (2 * FRAC_BITS);
					res_q    <= '0;
					bit_q    <= SQW'(1) << (SQW - 2);
					sq_cnt_q <= '0;
					state_q  <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_cnt_q == SCW'(GW)) begin
						oct_q   <= '0;
						state_q <= ST_PRD;
					end else begin
						if (sq_ge) begin
							rem_q <= rem_q - sq_t;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q    <= bit_q >> 2;
						sq_cnt_q <= sq_cnt_q + SCW'(1);
					end
				end
				ST_PRD: begin
					if (p_on) state_q <= ST_PWR;
					else if (oct_q == 3'd7) state_q <= ST_NEXT;
					else oct_q <= oct_q + 3'd1;
				end
				ST_PWR: begin
					oct_q   <= oct_q + 3'd1;
					state_q <= (oct_q == 3'd7) ? ST_NEXT : ST_PRD;
				end
				ST_NEXT: begin
					if ({1'b0, rr} > two_kk) begin
						k_q     <= k_q + RAD_W'(1);
						state_q <= ST_RSET;
					end else if (r_q < robot_rad_q) begin
						r_q     <= r_q + RAD_W'(1);
						k_q     <= '0;
						state_q <= ST_RSET;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CHK: begin
					chk_pend_s1 <= !chk_end_q;
					chk_x_s1    <= chk_x_q;
					if (!chk_end_q) begin
						if (chk_y_q == YW'(GRID_HEIGHT - 1)) begin
							chk_y_q <= '0;
							if (chk_x_q == XW'(GRID_WIDTH - 1)) chk_end_q <= 1'b1;
							else chk_x_q <= chk_x_q + XW'(1);
						end else begin
							chk_y_q <= chk_y_q + YW'(1);
						end
					end
					// Scan order is column-major, so the first hit is the lowest column.
					if (chk_pend_s1 && rd_q == LETHAL) begin
						stop_q  <= CW'(chk_x_s1) < CW'(stop_cols_q);
						state_q <= ST_DONE;
					end else if (chk_end_q && !chk_pend_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					clr_op_q <= 1'b0;
					if (!m_tvalid || m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for obstacle_grid_inflation_unit: directed and random
// mark/read/clear/check words against an in-bench cost grid predictor.
// Depends on ogi_pkg and the unit RTL.
`timescale 1ns / 1ps

module testbench;
	import ogi_pkg::*;

	localparam int GW = 128;
	localparam int GH = 128;
	localparam int STALL_LIMIT = 600000;

	typedef struct packed {
		logic [COST_W-1:0] cell_value;
		logic              point_used;
		logic              stop;
	} grid_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0] s_tuser = OP_READ;
	logic m_tvalid;
	logic m_tready = 0;
	logic [15:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = REG_ROBOT_RAD;
	logic [7:0] cfg_data = '0;

	logic [COST_W-1:0] grid_model [GW*GH];
	logic [RAD_W-1:0] robot_rad, sq_rad, rect_rad;
	logic [COST_W-1:0] sq_cost, rect_cost, robot_cost;
	logic [COL_W-1:0] stop_cols;

	grid_result_t pending_results[$];
	int errors = 0;
	bit calm = 0;
	int stall_cycles = 0;

	obstacle_grid_inflation_unit dut (.*);

	always #10 clk = ~clk;

	// Receiver stalls at random except in the calm stretch.
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 22);
	end

	always @(posedge clk) begin
		grid_result_t got, want;
		if (m_tvalid && m_tready) begin
			got.cell_value = m_tdata[6:0];
			got.point_used = m_tdata[7];
			got.stop = m_tdata[8];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %p", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.cell_value !== want.cell_value) begin
					$display("%0t: cell_value expected %0d actual %0d", $time,
						want.cell_value, got.cell_value);
					errors++;
				end
				if (got.point_used !== want.point_used) begin
					$display("%0t: point_used expected %0d actual %0d", $time,
						want.point_used, got.point_used);
					errors++;
				end
				if (got.stop !== want.stop) begin
					$display("%0t: stop expected %0d actual %0d", $time,
						want.stop, got.stop);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Truncation toward zero of (a + fraction) / 2^8, fraction nonzero if inexact.
	function automatic longint to_cell(longint a, int inexact);
		if (a >= 0)
			return a >>> FRAC_BITS_DEF;
		return -((-a - inexact) >>> FRAC_BITS_DEF);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic void merge_cell(longint px, longint py, longint fx, int ix,
			longint fy, int iy, logic [COST_W-1:0] cost);
		longint cx, cy;
		cx = to_cell(px + fx, ix);
		cy = to_cell(py + fy, iy);
		if (cx >= 0 && cx < GW && cy >= 0 && cy < GH)
			if (grid_model[cy*GW + cx] < cost)
				grid_model[cy*GW + cx] = cost;
	endfunction

	function automatic void draw_ring(longint px, longint py, int r,
			logic [COST_W-1:0] cost);
		longint unsigned rr, k, scaled, g;
		longint gx, ky, ngx;
		int ix;
		rr = r * r;
		k = 0;
		forever begin
			scaled = (rr >= k*k ? rr - k*k : 0) << (2*FRAC_BITS_DEF);
			g = int_sqrt(scaled);
			ix = (g*g != scaled);
			gx = g;
			ky = k << FRAC_BITS_DEF;
			ngx = -gx - ix;
			merge_cell(px, py, gx, ix, ky, 0, cost);
			merge_cell(px, py, ky, 0, gx, ix, cost);
			merge_cell(px, py, -ky, 0, gx, ix, cost);
			merge_cell(px, py, ngx, ix, ky, 0, cost);
			merge_cell(px, py, ngx, ix, -ky, 0, cost);
			merge_cell(px, py, -ky, 0, ngx, ix, cost);
			merge_cell(px, py, ky, 0, ngx, ix, cost);
			merge_cell(px, py, gx, ix, -ky, 0, cost);
			if (!(rr > 2*k*k))
				break;
			k++;
		end
	endfunction

	function automatic grid_result_t predict_grid_op(logic [1:0] op,
			logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
		grid_result_t res = '0;
		longint px, py, cx, cy;
		bit found = 0;
		px = x;
		py = y;
		cx = to_cell(px, 0);
		cy = to_cell(py, 0);
		case (op)
			OP_MARK: begin
				if (cx >= 0 && cx < GW && cy >= 0 && cy < GH &&
						grid_model[cy*GW + cx] != LETHAL) begin
					grid_model[cy*GW + cx] = LETHAL;
					res.point_used = 1;
					for (int r = 1; r <= robot_rad; r++)
						draw_ring(px, py, r, r <= sq_rad ? sq_cost :
							(r <= rect_rad ? rect_cost : robot_cost));
				end
			end
			OP_READ: begin
				if (cx >= 0 && cx < GW && cy >= 0 && cy < GH)
					res.cell_value = grid_model[cy*GW + cx];
			end
			OP_CLEAR: begin
				foreach (grid_model[i])
					grid_model[i] = '0;
			end
			default: begin
				for (int c = 0; c < GW && !found; c++)
					for (int r = 0; r < GH && !found; r++)
						if (grid_model[r*GW + c] == LETHAL) begin
							found = 1;
							res.stop = (c < stop_cols);
						end
			end
		endcase
		return res;
	endfunction

	task automatic send_op(logic [1:0] op, logic signed [POS_W-1:0] x,
			logic signed [POS_W-1:0] y);
		if (!calm && $urandom_range(99) < 22) begin
			s_tvalid <= 0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 22);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {6'b0, y, x};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(predict_grid_op(op, x, y));
	endtask

	// Lowers valid and waits until every expected word has come back.
	task automatic drain;
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [7:0] value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_ROBOT_RAD:  robot_rad = value[5:0];
			REG_SQ_RAD:     sq_rad = value[5:0];
			REG_RECT_RAD:   rect_rad = value[5:0];
			REG_SQ_COST:    sq_cost = value[6:0];
			REG_RECT_COST:  rect_cost = value[6:0];
			REG_ROBOT_COST: robot_cost = value[6:0];
			default:        stop_cols = value;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all_regs(int rad, int sqr, int rcr, int sqc, int rcc,
			int rbc, int stc);
		write_reg(REG_ROBOT_RAD, 8'(rad));
		write_reg(REG_SQ_RAD, 8'(sqr));
		write_reg(REG_RECT_RAD, 8'(rcr));
		write_reg(REG_SQ_COST, 8'(sqc));
		write_reg(REG_RECT_COST, 8'(rcc));
		write_reg(REG_ROBOT_COST, 8'(rbc));
		write_reg(REG_STOP_COLS, 8'(stc));
	endtask

	task automatic test_defaults;
		send_op(OP_MARK, 21'sd2688, 21'sd5184);          // 10.5, 20.25
		send_op(OP_READ, 21'sd2560, 21'sd5120);
		send_op(OP_READ, 21'sd2560 + 21'sd512, 21'sd5120);
		send_op(OP_READ, 21'sd2560 + 21'sd1792, 21'sd5120);
		send_op(OP_MARK, 21'sd2600, 21'sd5200);          // already lethal
		send_op(OP_MARK, -21'sd128, -21'sd128);          // cell 0, rings mostly off grid
		send_op(OP_READ, -21'sd1, -21'sd255);
		send_op(OP_READ, -21'sd256, 21'sd0);
		send_op(OP_READ, 21'sd32768, 21'sd100);
		send_op(OP_MARK, 21'sh0FFFFF, 21'sh0FFFFF);
		send_op(OP_MARK, -21'sd1048576, -21'sd1048576);
		send_op(OP_READ, -21'sd1048576, 21'sh0FFFFF);
		send_op(OP_CHECK, 21'sd0, 21'sd0);
		drain();
	endtask

	task automatic test_clear_and_check;
		send_op(OP_CLEAR, 21'sd0, 21'sd0);
		send_op(OP_CHECK, 21'sd0, 21'sd0);
		send_op(OP_MARK, 21'sd100 <<< 8, 21'sd127 <<< 8);
		send_op(OP_CHECK, 21'sd0, 21'sd0);
		drain();
	endtask

	task automatic test_register_extremes;
		write_all_regs(0, 0, 0, 0, 0, 0, 255);
		send_op(OP_MARK, 21'sd20 <<< 8, 21'sd20 <<< 8);
		send_op(OP_READ, 21'sd21 <<< 8, 21'sd20 <<< 8);
		send_op(OP_CHECK, 21'sd0, 21'sd0);
		drain();
		write_all_regs(3, 1, 2, 127, 101, 0, 0);
		send_op(OP_MARK, 21'sd40 <<< 8, 21'sd40 <<< 8);
		send_op(OP_MARK, 21'sd41 <<< 8, 21'sd40 <<< 8);   // cell above 100 set to 100
		send_op(OP_READ, 21'sd41 <<< 8, 21'sd40 <<< 8);
		send_op(OP_CHECK, 21'sd0, 21'sd0);
		drain();
		write_all_regs(63, 63, 63, 99, 1, 100, 128);
		send_op(OP_MARK, 21'sd16500, 21'sd16300);
		send_op(OP_READ, 21'sd16500 + 21'sd7680, 21'sd16300);
		send_op(OP_READ, 21'sd200, 21'sd300);
		drain();
	endtask

	task automatic test_random_traffic;
		int v, ox, oy;
		logic [1:0] op;
		for (int phase = 0; phase < 11; phase++) begin
			calm = (phase == 5);
			write_all_regs($urandom_range(1, 4), $urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 127), $urandom_range(0, 255));
			for (int n = 0; n < 105; n++) begin
				v = $urandom_range(99);
				op = v < 40 ? OP_MARK : (v < 97 ? OP_READ : (v < 98 ? OP_CLEAR : OP_CHECK));
				if ($urandom_range(99) < 8) begin
					send_op(op, POS_W'($urandom), POS_W'($urandom));
				end else begin
					ox = $urandom_range(0, 33279) - 512;
					oy = $urandom_range(0, 33279) - 512;
					send_op(op, POS_W'(ox), POS_W'(oy));
				end
			end
			// Hold the sender until the unit has answered everything.
			drain();
		end
		calm = 0;
	endtask

	initial begin
		robot_rad = ROBOT_RAD_RST;
		sq_rad = SQ_RAD_RST;
		rect_rad = RECT_RAD_RST;
		sq_cost = SQ_COST_RST;
		rect_cost = RECT_COST_RST;
		robot_cost = ROBOT_COST_RST;
		stop_cols = STOP_COLS_RST;
		foreach (grid_model[i])
			grid_model[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_defaults();
		test_clear_and_check();
		test_register_extremes();
		test_random_traffic();
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== obstacle_grid_inflation_unit.f =====
rtl/ogi_pkg.sv
rtl/obstacle_grid_inflation_unit.sv
bench/testbench.sv
